/* rtl/pfc_pkg.sv */
// Shared types and constants of the Playfair digraph cipher core.
// Depends on nothing; every other file of the block imports it.
package pfc_pkg;

	localparam int SIDE = 5;

	typedef logic [4:0]  code_t;
	typedef logic [2:0]  idx_t;
	typedef logic [24:0] row_t;
	typedef row_t [SIDE-1:0] square_t;

	// Standard square: a b c d e / f g h i k / l m n o p / q r s t u / v w x y z.
	localparam square_t SQUARE_RESET = {
		25'd27025109, 25'd21613104, 25'd16201099, 25'd10755269, 25'd4294688
	};

	localparam code_t CODE_I = 5'd8;
	localparam code_t CODE_J = 5'd9;
	localparam code_t CODE_X = 5'd23;
	localparam code_t CODE_Z = 5'd25;

	localparam logic [6:0] CHAR_A = 7'd97;

	localparam logic [2:0] REG_ROW_LAST = 3'd4;
	localparam logic [2:0] REG_MODE     = 3'd5;

	// One queue entry: one or two digraphs produced by one input character.
	typedef struct packed {
		code_t a0;
		code_t b0;
		code_t a1;
		code_t b1;
		logic  two;
		logic  eom;
	} job_t;

endpackage

/* rtl/pfc_front.sv */
// Front end: classifies input characters, keeps the pending letter and forms digraphs.
// Depends on pfc_pkg; pushes jobs into pfc_queue.
module pfc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    char_in,
	input  logic          end_of_message,
	input  logic          decrypt_mode,
	input  logic          queue_full,
	output logic          push,
	output pfc_pkg::job_t push_data
);
	import pfc_pkg::*;

	code_t held_q;
	logic  held_valid_q;

	logic       accept;
	logic       is_lower;
	logic       is_upper;
	logic       is_letter;
	logic [7:0] diff;
	code_t      code;
	code_t      held_next;
	logic       valid_next;
	logic       have_first;
	logic       have_second;
	job_t       job;

	function automatic code_t filler_for(code_t c);
		return (c == CODE_X) ? CODE_Z : CODE_X;
	endfunction

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		is_lower  = char_in inside {[8'h61:8'h7a]};
		is_upper  = char_in inside {[8'h41:8'h5a]};
		is_letter = is_lower || is_upper;
		diff      = char_in - (is_lower ? 8'h61 : 8'h41);
		code      = diff[4:0];
		if (code == CODE_J) begin
			code = CODE_I;
		end

		held_next   = held_q;
		valid_next  = held_valid_q;
		have_first  = 1'b0;
		have_second = 1'b0;
		job         = '0;
		job.eom     = end_of_message;

		if (is_letter) begin
			if (!held_valid_q) begin
				held_next  = code;
				valid_next = 1'b1;
			end else if (!decrypt_mode && code == held_q) begin
				job.a0     = held_q;
				job.b0     = filler_for(held_q);
				have_first = 1'b1;
				held_next  = code;
			end else begin
				job.a0     = held_q;
				job.b0     = code;
				have_first = 1'b1;
				held_next  = '0;
				valid_next = 1'b0;
			end
		end

		if (end_of_message) begin
			if (valid_next) begin
				// The flush pair takes the second slot only when a pair already sits in the first.
				if (have_first) begin
					job.a1      = held_next;
					job.b1      = filler_for(held_next);
					have_second = 1'b1;
				end else begin
					job.a0     = held_next;
					job.b0     = filler_for(held_next);
					have_first = 1'b1;
				end
			end
			held_next  = '0;
			valid_next = 1'b0;
		end
		job.two = have_second;
	end

	assign push      = accept && have_first;
	assign push_data = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			held_valid_q <= 1'b0;
		end else if (accept) begin
			held_q       <= held_next;
			held_valid_q <= valid_next;
		end
	end

endmodule

/* rtl/pfc_queue.sv */
// Short job queue between the front end and the cipher back end.
// Depends on pfc_pkg for the job type.
module pfc_queue #(
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  pfc_pkg::job_t              push_data,
	output logic                       full,
	input  logic                       pop,
	output pfc_pkg::job_t              head,
	output logic                       head_valid,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	import pfc_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign count      = count_q;
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/pfc_back.sv */
// Back end: looks up each digraph in the key square and emits its two letters.
// Depends on pfc_pkg; pops jobs from pfc_queue and drives the output channel.
module pfc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  pfc_pkg::job_t    head,
	input  logic             head_valid,
	output logic             pop,
	input  pfc_pkg::square_t square,
	input  logic             decrypt_mode,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [6:0]       char_out,
	output logic             last_of_run,
	output logic             message_done
);
	import pfc_pkg::*;

	logic       pidx_q;
	logic       out_valid_q;
	logic [6:0] char_q;
	logic       last_q;
	logic       done_q;
	logic       sec_valid_q;
	logic [6:0] sec_char_q;
	logic       sec_last_q;
	logic       sec_done_q;

	logic  load_en;
	logic  take_pair;
	logic  last_pair;
	code_t pa;
	code_t pb;
	idx_t  ra, ca, rb, cb;
	code_t oa;
	code_t ob;

	// First matching cell in row-major order; a missing letter sits at row 0, column 0.
	function automatic logic [5:0] locate(square_t sq, code_t c);
		logic [SIDE*SIDE-1:0] hit;
		logic [5:0]           pos;
		row_t                 rw;
		for (int r = 0; r < SIDE; r++) begin
			rw = sq[r];
			for (int k = 0; k < SIDE; k++) begin
				hit[r*SIDE + k] = (rw[5*k +: 5] == c);
			end
		end
		pos = '0;
		for (int i = SIDE*SIDE - 1; i >= 0; i--) begin
			if (hit[i]) begin
				pos = {3'(i / SIDE), 3'(i % SIDE)};
			end
		end
		return pos;
	endfunction

	function automatic code_t square_cell(square_t sq, idx_t r, idx_t c);
		row_t rw;
		rw = sq[r];
		return rw[5*c +: 5];
	endfunction

	function automatic idx_t wrap_step(idx_t v, logic dec);
		logic [3:0] s;
		s = {1'b0, v} + (dec ? 4'd4 : 4'd1);
		if (s >= 4'd5) begin
			s = s - 4'd5;
		end
		return s[2:0];
	endfunction

	function automatic logic [6:0] letter_char(code_t c);
		code_t k;
		k = (c > CODE_Z) ? CODE_Z : c;
		return CHAR_A + {2'b00, k};
	endfunction

	assign load_en   = !out_valid_q || out_ready;
	assign take_pair = load_en && !sec_valid_q && head_valid;
	assign last_pair = !head.two || pidx_q;
	assign pop       = take_pair && last_pair;
	assign pa        = pidx_q ? head.a1 : head.a0;
	assign pb        = pidx_q ? head.b1 : head.b0;

	always_comb begin
		{ra, ca} = locate(square, pa);
		{rb, cb} = locate(square, pb);
		if (ra == rb) begin
			oa = square_cell(square, ra, wrap_step(ca, decrypt_mode));
			ob = square_cell(square, rb, wrap_step(cb, decrypt_mode));
		end else if (ca == cb) begin
			oa = square_cell(square, wrap_step(ra, decrypt_mode), ca);
			ob = square_cell(square, wrap_step(rb, decrypt_mode), cb);
		end else begin
			oa = square_cell(square, ra, cb);
			ob = square_cell(square, rb, ca);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pidx_q      <= 1'b0;
			out_valid_q <= 1'b0;
			sec_valid_q <= 1'b0;
		end else if (load_en) begin
			if (sec_valid_q) begin
				out_valid_q <= 1'b1;
				sec_valid_q <= 1'b0;
			end else if (head_valid) begin
				out_valid_q <= 1'b1;
				sec_valid_q <= 1'b1;
				pidx_q      <= last_pair ? 1'b0 : ~pidx_q;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			if (sec_valid_q) begin
				char_q <= sec_char_q;
				last_q <= sec_last_q;
				done_q <= sec_done_q;
			end else if (head_valid) begin
				char_q     <= letter_char(oa);
				last_q     <= 1'b0;
				done_q     <= 1'b0;
				sec_char_q <= letter_char(ob);
				sec_last_q <= last_pair;
				sec_done_q <= last_pair && head.eom;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign char_out     = char_q;
	assign last_of_run  = last_q;
	assign message_done = done_q;

endmodule

/* rtl/playfair_digraph_cipher_core.sv */
// Playfair digraph cipher core: one input character per cycle while the job queue has room, one
// output letter per cycle while out_ready holds. A digraph's first letter passes through the job
// queue and the output register, its second through a holding register and then the output
// register; the back end emits one letter a cycle unless out_ready stalls it, and input stalls when the queue fills.
// Reset loads the standard key square, selects encrypt, empties the queue and
// clears the pending letter.
module playfair_digraph_cipher_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [24:0] wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_in,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  char_out,
	output logic        last_of_run,
	output logic        message_done
);
	import pfc_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	square_t square_q;
	logic    decrypt_q;

	logic          q_full;
	logic          q_push;
	job_t          q_push_data;
	logic          q_pop;
	job_t          q_head;
	logic          q_head_valid;
	logic [CW-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			square_q  <= SQUARE_RESET;
			decrypt_q <= 1'b0;
		end else if (wr_en) begin
			if (wr_index <= REG_ROW_LAST) begin
				square_q[wr_index] <= wr_data;
			end else if (wr_index == REG_MODE) begin
				decrypt_q <= wr_data[0];
			end
		end
	end

	pfc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.char_in        (char_in),
		.end_of_message (end_of_message),
		.decrypt_mode   (decrypt_q),
		.queue_full     (q_full),
		.push           (q_push),
		.push_data      (q_push_data)
	);

	pfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_push_data),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.head_valid (q_head_valid),
		.count      (q_count)
	);

	pfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.head_valid   (q_head_valid),
		.pop          (q_pop),
		.square       (square_q),
		.decrypt_mode (decrypt_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.char_out     (char_out),
		.last_of_run  (last_of_run),
		.message_done (message_done)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= CW'(QUEUE_DEPTH))
		else $error("job queue count exceeds its depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("front end pushed into a full queue");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_done |-> last_of_run)
		else $error("message end flagged on a letter that does not end its run");

	a_letter_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_out >= 7'd97) && (char_out <= 7'd122))
		else $error("output letter outside a to z");

endmodule
